// ===== design/assert_macros.svh =====
// assert_macros.svh: assertion macros for the checker module cia_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== design/cia_pkg.sv =====
// cia_pkg: types, codes and constants of the checked integer ALU.
// No dependencies.
package cia_pkg;
   localparam int WIDTH = 32;
   localparam int DEPTH = WIDTH + 2;   // pipeline stages from entry to output register

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0, ACT_SUB = 3'd1, ACT_MUL = 3'd2,
      ACT_DIV = 3'd3, ACT_REM = 3'd4, ACT_MOD = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_HIGH = 3'd1, ST_LOW = 3'd2, ST_MUL = 3'd3, ST_DZERO = 3'd4
   } status_type;

   // Operation carried down the pipe next to the divider state.
   typedef struct packed {
      logic [2:0]       act;
      logic             sa;
      logic             sb;
      logic [WIDTH-1:0] ma;
      logic [WIDTH-1:0] mb;
      logic [WIDTH-1:0] fast_val;   // add/sub/mul result
      logic [2:0]       fast_st;
   } op_type;

   typedef struct packed {
      logic [WIDTH-1:0] rem;
      logic [WIDTH-1:0] quo;   // dividend bits shift out, quotient bits shift in
   } div_type;
endpackage

// ===== design/cia_front.sv =====
// cia_front: stage-one decode; add, subtract and a split multiply.
// Depends on cia_pkg.
module cia_front import cia_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [2:0]       action,
   input  logic [WIDTH-1:0] operand_a,
   input  logic [WIDTH-1:0] operand_b,
   output logic             out_valid,
   output op_type           out_op
);
   localparam int H = WIDTH / 2;

   logic             sa, sb;
   logic [WIDTH-1:0] ma, mb, sum, dif;
   logic [2:0]       st;
   logic [WIDTH-1:0] val;
   // stage-one registers
   logic             v1_ff;
   logic [2:0]       act1_ff;
   logic             sa1_ff, sb1_ff;
   logic [WIDTH-1:0] ma1_ff, mb1_ff, val1_ff;
   logic [2:0]       st1_ff;
   logic [WIDTH-1:0] pll_ff, plh_ff, phl_ff, phh_ff;
   // multiply combine
   logic [2*WIDTH:0] prod;
   logic             neg;
   logic [WIDTH-1:0] lim, mval;
   logic             movf;

   assign sa  = operand_a[WIDTH-1];
   assign sb  = operand_b[WIDTH-1];
   assign ma  = sa ? (~operand_a + 1'b1) : operand_a;
   assign mb  = sb ? (~operand_b + 1'b1) : operand_b;
   assign sum = operand_a + operand_b;
   assign dif = operand_a - operand_b;

   // judge add and subtract
   always_comb begin
      st  = ST_OK;
      val = '0;
      if (action == ACT_ADD) begin
         if (sa == sb && sum[WIDTH-1] != sa) st = sa ? ST_LOW : ST_HIGH;
         else val = sum;
      end else if (action == ACT_SUB) begin
         if (sa != sb && dif[WIDTH-1] != sa) st = sa ? ST_LOW : ST_HIGH;
         else val = dif;
      end
   end

   // register the decoded operands, add/sub result and half-width partial products
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= in_valid;
      if (advance) begin
         act1_ff <= action;
         sa1_ff  <= sa;
         sb1_ff  <= sb;
         ma1_ff  <= ma;
         mb1_ff  <= mb;
         val1_ff <= val;
         st1_ff  <= st;
         pll_ff  <= ma[H-1:0] * mb[H-1:0];
         plh_ff  <= ma[H-1:0] * mb[WIDTH-1:H];
         phl_ff  <= ma[WIDTH-1:H] * mb[H-1:0];
         phh_ff  <= ma[WIDTH-1:H] * mb[WIDTH-1:H];
      end
   end

   // combine partials and judge the product
   always_comb begin
      prod = {1'b0, phh_ff, pll_ff}
           + ({{(WIDTH+1){1'b0}}, plh_ff} << H)
           + ({{(WIDTH+1){1'b0}}, phl_ff} << H);
      neg  = sa1_ff != sb1_ff;
      lim  = neg ? {1'b1, {(WIDTH-1){1'b0}}} : {1'b0, {(WIDTH-1){1'b1}}};
      movf = (prod[2*WIDTH:WIDTH] != '0) || (prod[WIDTH-1:0] > lim);
      mval = neg ? (~prod[WIDTH-1:0] + 1'b1) : prod[WIDTH-1:0];
   end

   assign out_valid       = v1_ff;
   assign out_op.act      = act1_ff;
   assign out_op.sa       = sa1_ff;
   assign out_op.sb       = sb1_ff;
   assign out_op.ma       = ma1_ff;
   assign out_op.mb       = mb1_ff;
   assign out_op.fast_val = (act1_ff == ACT_MUL) ? (movf ? '0 : mval) : val1_ff;
   assign out_op.fast_st  = (act1_ff == ACT_MUL) ? (movf ? ST_MUL : ST_OK) : st1_ff;
endmodule

// ===== design/cia_divstage.sv =====
// cia_divstage: one restoring-division step of the pipelined divider.
// Depends on cia_pkg.
module cia_divstage import cia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  op_type  in_op,
   input  div_type in_div,
   output logic    out_valid,
   output op_type  out_op,
   output div_type out_div
);
   logic             v_ff;
   op_type           op_ff;
   div_type          div_ff;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   div_type          nxt;

   // shift in one dividend bit, subtract if it fits
   always_comb begin
      trial = {in_div.rem, in_div.quo[WIDTH-1]};
      diff  = trial - {1'b0, in_op.mb};
      nxt.rem = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
      nxt.quo = {in_div.quo[WIDTH-2:0], ~diff[WIDTH]};
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (advance) v_ff <= in_valid;
      if (advance) begin
         op_ff  <= in_op;
         div_ff <= nxt;
      end
   end

   assign out_valid = v_ff;
   assign out_op    = op_ff;
   assign out_div   = div_ff;
endmodule

// ===== design/cia_back.sv =====
// cia_back: final selection of value and status, output register.
// Depends on cia_pkg.
module cia_back import cia_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  op_type           in_op,
   input  div_type          in_div,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_value,
   output logic [2:0]       out_status
);
   logic             v_ff;
   logic [WIDTH-1:0] val_ff, val;
   logic [2:0]       st_ff, st;
   logic [WIDTH-1:0] q, r;
   logic             neg;

   assign q   = in_div.quo;
   assign r   = in_div.rem;
   assign neg = in_op.sa != in_op.sb;

   // pick the result by action
   always_comb begin
      val = '0;
      st  = ST_OK;
      case (in_op.act)
         ACT_ADD, ACT_SUB, ACT_MUL: begin
            val = in_op.fast_val;
            st  = in_op.fast_st;
         end
         ACT_DIV, ACT_REM, ACT_MOD: begin
            if (in_op.mb == '0) st = ST_DZERO;
            else if (in_op.act == ACT_DIV) begin
               if (!neg && q[WIDTH-1]) st = ST_HIGH;
               else val = neg ? (~q + 1'b1) : q;
            end else if (in_op.act == ACT_REM) begin
               val = in_op.sa ? (~r + 1'b1) : r;
            end else if (r != '0) begin
               val = in_op.sa ? (in_op.mb - r) : r;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (advance) v_ff <= in_valid;
      if (advance) begin
         val_ff <= val;
         st_ff  <= st;
      end
   end

   assign out_valid  = v_ff;
   assign out_value  = val_ff;
   assign out_status = st_ff;
endmodule

// ===== design/checked_int32_alu_top.sv =====
// checked_int32_alu_top: top level of the overflow-checked integer ALU.
// Depends on cia_pkg, cia_front, cia_divstage, cia_back.
//
// One result beat per request beat, in order. The pipe takes a new request
// every cycle in which it advances. It has WIDTH+2 register stages (34 at
// WIDTH 32): one stage for decode and multiply partial products, one
// restoring-divide stage per quotient bit, and the output register. A request
// beat passes through these registers in that order, stalling with the pipe.
// All actions share the same path so order is kept.
// The whole pipe stalls together when the output beat waits.
module checked_int32_alu_top import cia_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_action,
   input  logic signed [WIDTH-1:0] req_operand_a,
   input  logic signed [WIDTH-1:0] req_operand_b,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [WIDTH-1:0] rsp_value,
   output logic [2:0]              rsp_status
);
   logic    advance;
   logic    v   [WIDTH+1];
   op_type  op  [WIDTH+1];
   div_type dv  [WIDTH+1];

   // advance whenever the output slot is free or drains
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   cia_front u_front (
      .clock, .reset, .advance,
      .in_valid(req_valid), .action(req_action),
      .operand_a(req_operand_a), .operand_b(req_operand_b),
      .out_valid(v[0]), .out_op(op[0])
   );

   assign dv[0].rem = '0;
   assign dv[0].quo = op[0].ma;

   for (genvar i = 0; i < WIDTH; i++) begin : g_div
      cia_divstage u_stage (
         .clock, .reset, .advance,
         .in_valid(v[i]), .in_op(op[i]), .in_div(dv[i]),
         .out_valid(v[i+1]), .out_op(op[i+1]), .out_div(dv[i+1])
      );
   end

   cia_back u_back (
      .clock, .reset, .advance,
      .in_valid(v[WIDTH]), .in_op(op[WIDTH]), .in_div(dv[WIDTH]),
      .out_valid(rsp_valid), .out_value(rsp_value), .out_status(rsp_status)
   );
endmodule

// ===== design/cia_checker.sv =====
// cia_checker: port-level assertions for checked_int32_alu_top, with bind.
// Depends on cia_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cia_checker import cia_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [WIDTH-1:0] rsp_value,
   input logic [2:0]       rsp_status
);
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_value == '0, "error beat with nonzero value")
   `ASSERT_IMPLIES(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_DZERO, "status code out of range")
   `ASSERT_IMPLIES(a_ready_free, clock, reset, !rsp_valid, req_ready, "request stalled with empty output")
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_status), "stalled result beat changed")
endmodule

bind checked_int32_alu_top cia_checker u_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_value, .rsp_status
);

// ===== test/tb.sv =====
// tb: self-checking bench for checked_int32_alu_top, in-order valid/ready beats.
// Depends on cia_pkg and the checked_int32_alu_top RTL.
module tb;
   import cia_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;
   localparam int LATENCY = DEPTH;

   typedef struct {
      logic [2:0]        act;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic              typed;   // expected value typed into the row
      logic signed [31:0] val;
      status_type        st;
   } vector_row;

   typedef struct {
      logic signed [31:0] val;
      logic [2:0]         st;
   } alu_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_action = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_value;
   logic [2:0] rsp_status;

   alu_result pending_results[$];
   int mismatches = 0;
   int quiet_span = 0;      // cycles left with no idling on either side
   int hold_rsp = 0;        // cycles left of forced receiver hold-off

   checked_int32_alu_top u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Compute the expected result of one beat from magnitudes and signs.
   function automatic alu_result alu_predict(logic [2:0] act, logic [31:0] a,
                                             logic [31:0] b);
      alu_result r;
      logic sa, sb, sr, neg;
      logic [31:0] ma, mb, s, q, m;
      logic [63:0] p;
      sa = a[31];
      sb = b[31];
      ma = sa ? -a : a;
      mb = sb ? -b : b;
      neg = sa ^ sb;
      r.val = '0;
      r.st = ST_OK;
      case (act)
         ACT_ADD, ACT_SUB: begin
            s = (act == ACT_ADD) ? a + b : a - b;
            sr = s[31];
            if (((act == ACT_ADD) ? (sa == sb) : (sa != sb)) && sr != sa)
               r.st = sa ? ST_LOW : ST_HIGH;
            else
               r.val = s;
         end
         ACT_MUL: begin
            p = {32'd0, ma} * {32'd0, mb};
            if (p > (neg ? 64'h80000000 : 64'h7fffffff)) r.st = ST_MUL;
            else r.val = neg ? -p[31:0] : p[31:0];
         end
         ACT_DIV, ACT_REM, ACT_MOD: begin
            if (mb == 0) begin
               r.st = ST_DZERO;
            end else begin
               q = ma / mb;
               m = ma % mb;
               if (act == ACT_DIV) begin
                  if (!neg && q > 32'h7fffffff) r.st = ST_HIGH;
                  else r.val = neg ? -q : q;
               end else if (act == ACT_REM) begin
                  r.val = sa ? -m : m;
               end else begin
                  r.val = (m == 0) ? 32'd0 : (sa ? mb - m : m);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Directed rows: extremes, each action, each error case.
   vector_row rows[] = '{
      '{ACT_ADD, MAXV, 32'sd1, 1, 32'sd0, ST_HIGH},
      '{ACT_ADD, MINV, -32'sd1, 1, 32'sd0, ST_LOW},
      '{ACT_ADD, MAXV, MINV, 1, -32'sd1, ST_OK},
      '{ACT_ADD, 32'sd5, -32'sd7, 0, 0, ST_OK},
      '{ACT_SUB, 32'sd0, MINV, 1, 32'sd0, ST_HIGH},
      '{ACT_SUB, MINV, 32'sd1, 1, 32'sd0, ST_LOW},
      '{ACT_SUB, -32'sd1, MINV, 1, MAXV, ST_OK},
      '{ACT_MUL, MINV, -32'sd1, 1, 32'sd0, ST_MUL},
      '{ACT_MUL, MINV, 32'sd1, 1, MINV, ST_OK},
      '{ACT_MUL, MAXV, -32'sd1, 1, -MAXV, ST_OK},
      '{ACT_MUL, 32'sd65536, 32'sd65536, 1, 32'sd0, ST_MUL},
      '{ACT_MUL, -32'sd65536, 32'sd32768, 1, MINV, ST_OK},
      '{ACT_DIV, MINV, -32'sd1, 1, 32'sd0, ST_HIGH},
      '{ACT_DIV, 32'sd7, 32'sd0, 1, 32'sd0, ST_DZERO},
      '{ACT_DIV, -32'sd7, 32'sd2, 1, -32'sd3, ST_OK},
      '{ACT_DIV, MINV, MINV, 1, 32'sd1, ST_OK},
      '{ACT_REM, MINV, -32'sd1, 1, 32'sd0, ST_OK},
      '{ACT_REM, -32'sd7, 32'sd2, 1, -32'sd1, ST_OK},
      '{ACT_REM, 32'sd7, 32'sd0, 1, 32'sd0, ST_DZERO},
      '{ACT_MOD, -32'sd7, 32'sd2, 1, 32'sd1, ST_OK},
      '{ACT_MOD, -32'sd6, -32'sd3, 1, 32'sd0, ST_OK},
      '{ACT_MOD, -32'sd5, MINV, 1, -32'sd5 - MINV, ST_OK},
      '{ACT_MOD, 32'sd5, 32'sd0, 1, 32'sd0, ST_DZERO},
      '{3'd6, MAXV, MINV, 1, 32'sd0, ST_OK},
      '{3'd7, -32'sd1, -32'sd1, 1, 32'sd0, ST_OK}
   };

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return MAXV - $urandom_range(2);
         1: return MINV + $urandom_range(2);
         2: return $urandom_range(4) - 2;
         3: return $urandom_range(255) - 128;
         4: return $urandom_range(65535) - 32768;
         default: return $urandom;
      endcase
   endfunction

   // Offer one beat at the falling edge and hold it until accepted.
   // Valid stays high after acceptance unless an idle cycle drops it.
   task automatic send_beat(logic [2:0] act, logic [31:0] a, logic [31:0] b);
      while (quiet_span == 0 && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver: stall at random, plus forced hold-off windows.
   always @(negedge clock) begin
      if (quiet_span > 0) quiet_span <= quiet_span - 1;
      if (hold_rsp > 0) hold_rsp <= hold_rsp - 1;
      rsp_ready <= !reset && hold_rsp <= 1 &&
                   (quiet_span > 0 || $urandom_range(99) >= 14);
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      alu_result want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: value %0d status %0d", rsp_value, rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (want.val !== rsp_value || want.st !== rsp_status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want %0d/%0d got %0d/%0d",
                           want.val, want.st, rsp_value, rsp_status);
            end
         end
      end
   end

   // Record an expectation at the edge where the request beat is accepted.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         pending_results.push_back(alu_predict(req_action, req_operand_a,
                                               req_operand_b));
   end

   initial begin
      alu_result typed_row;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed table; typed rows are checked against the predictor too.
      foreach (rows[i]) begin
         if (rows[i].typed) begin
            typed_row = alu_predict(rows[i].act, rows[i].a, rows[i].b);
            if (typed_row.val !== rows[i].val || typed_row.st !== rows[i].st) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("row %0d: table %0d/%0d predicted %0d/%0d", i,
                           rows[i].val, rows[i].st, typed_row.val, typed_row.st);
            end
         end
         send_beat(rows[i].act, rows[i].a, rows[i].b);
      end
      // Random beats with a quiet stretch, a receiver hold-off and a drain pause.
      for (int n = 0; n < 1000; n++) begin
         if (n == 200) quiet_span <= 300;
         if (n == 500) hold_rsp <= 3 * LATENCY + 40;
         if (n == 700) begin
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         send_beat($urandom_range(99) < 3 ? 3'(6 + $urandom_range(1))
                                          : 3'($urandom_range(5)),
                   pick_operand(), pick_operand());
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #4ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/cia_pkg.sv
design/cia_front.sv
design/cia_divstage.sv
design/cia_back.sv
design/checked_int32_alu_top.sv
design/cia_checker.sv
test/tb.sv
